// ----- hdl/gbt_pkg.sv -----
// Shared constants and types of the glyph bitmap trimmer.
// Used by the front, the glyph queue, the back and the top level.
`timescale 1ns / 1ps
package gbt_pkg;

  localparam int MAX_WIDTH   = 32;
  localparam int MAX_HEIGHT  = 32;
  localparam int ROW_W       = 32;
  localparam int ROW_IDX_W   = $clog2(MAX_HEIGHT);
  localparam int MEM_AW      = ROW_IDX_W + 1;
  localparam int MEM_DEPTH   = 2 * MAX_HEIGHT;
  localparam int CFG_W       = 6;
  localparam int CNT_W       = 6;
  localparam int CFG_IDX_W   = 1;
  localparam int OUT_TDATA_W = 40;

  localparam logic [CFG_W-1:0] WIDTH_RESET  = 6'd16;
  localparam logic [CFG_W-1:0] HEIGHT_RESET = 6'd16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } cfg_reg_t;

  // One finished glyph, handed from the front to the back.
  typedef struct packed {
    logic [CNT_W-1:0] rows;
    logic [CFG_W-1:0] width;
    logic [ROW_W-1:0] uni;
  } desc_t;

  // Row store write port, driven by the front.
  typedef struct packed {
    logic              en;
    logic [MEM_AW-1:0] addr;
    logic [ROW_W-1:0]  data;
  } mem_wr_t;

endpackage

// ----- hdl/gbt_front.sv -----
// Front of the glyph bitmap trimmer: configuration registers, row intake,
// column union and row count. Depends on gbt_pkg.
`timescale 1ns / 1ps
module gbt_front import gbt_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  logic                 row_valid,
  output logic                 row_ready,
  input  logic [ROW_W-1:0]     row_bits,
  input  logic                 q_full,
  output logic                 q_push,
  output desc_t                q_desc,
  output mem_wr_t              wr
);

  logic [CFG_W-1:0] glyph_width;
  logic [CFG_W-1:0] glyph_height;
  logic [CNT_W-1:0] rows_loaded;
  logic [ROW_W-1:0] col_union;
  logic             wr_bank;

  logic [CFG_W-1:0] w_eff;
  logic [CFG_W-1:0] h_eff;
  logic [ROW_W-1:0] mask;
  logic [ROW_W-1:0] row_m;
  logic [ROW_W-1:0] union_next;
  logic [CNT_W-1:0] rows_next;
  logic             accept;
  logic             glyph_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      glyph_width  <= WIDTH_RESET;
      glyph_height <= HEIGHT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WIDTH:  glyph_width  <= cfg_wdata;
        REG_HEIGHT: glyph_height <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    w_eff = glyph_width;
    if (glyph_width == '0) w_eff = CFG_W'(1);
    else if (glyph_width > CFG_W'(MAX_WIDTH)) w_eff = CFG_W'(MAX_WIDTH);
    h_eff = glyph_height;
    if (glyph_height == '0) h_eff = CFG_W'(1);
    else if (glyph_height > CFG_W'(MAX_HEIGHT)) h_eff = CFG_W'(MAX_HEIGHT);
  end

  // Keep the w leading bits; padding below the row end counts as blank.
  assign mask       = ~({ROW_W{1'b1}} >> w_eff);
  assign row_m      = row_bits & mask;
  assign union_next = col_union | row_m;
  assign rows_next  = rows_loaded + CNT_W'(1);

  assign row_ready  = !q_full;
  assign accept     = row_valid && row_ready;
  assign glyph_done = accept && (rows_next >= h_eff);

  assign wr.en   = accept;
  assign wr.addr = {wr_bank, rows_loaded[ROW_IDX_W-1:0]};
  assign wr.data = row_m;

  assign q_push      = glyph_done;
  assign q_desc.rows = rows_next;
  assign q_desc.width = w_eff;
  assign q_desc.uni  = union_next & mask;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_loaded <= '0;
      col_union   <= '0;
      wr_bank     <= 1'b0;
    end else if (accept) begin
      if (glyph_done) begin
        rows_loaded <= '0;
        col_union   <= '0;
        wr_bank     <= !wr_bank;
      end else begin
        rows_loaded <= rows_next;
        col_union   <= union_next;
      end
    end
  end

endmodule

// ----- hdl/gbt_queue.sv -----
// Two-entry queue of finished glyph descriptors between front and back.
// One entry per row store bank. Depends on gbt_pkg.
`timescale 1ns / 1ps
module gbt_queue import gbt_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  desc_t push_desc,
  output logic  full,
  output logic  valid,
  output desc_t head,
  input  logic  pop
);

  desc_t      entries [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;

  assign full  = (count == 2'd2);
  assign valid = (count != 2'd0);
  assign head  = entries[rptr];

  always_ff @(posedge clk) begin
    if (push) entries[wptr] <= push_desc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= !wptr;
      if (pop) rptr <= !rptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- hdl/gbt_back.sv -----
// Back of the glyph bitmap trimmer: double-banked row store, blank column
// measurement a byte per cycle, and row emission through a two-entry skid
// buffer. Depends on gbt_pkg.
`timescale 1ns / 1ps
module gbt_back import gbt_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  mem_wr_t          wr,
  input  logic             q_valid,
  input  desc_t            q_desc,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [ROW_W-1:0] trimmed_row,
  output logic [CFG_W-1:0] real_width,
  output logic             last_row
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_MEAS = 3'b010,
    ST_EMIT = 3'b100
  } back_state_t;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [CFG_W-1:0] rw;
    logic             last;
  } out_item_t;

  function automatic logic [3:0] lzc8(input logic [7:0] b);
    logic [3:0] n;
    logic       hit;
    n   = 4'd8;
    hit = 1'b0;
    for (int i = 7; i >= 0; i--) begin
      if (!hit && b[i]) begin
        n   = 4'(7 - i);
        hit = 1'b1;
      end
    end
    return n;
  endfunction

  function automatic logic [3:0] tzc8(input logic [7:0] b);
    logic [3:0] n;
    logic       hit;
    n   = 4'd8;
    hit = 1'b0;
    for (int i = 0; i < 8; i++) begin
      if (!hit && b[i]) begin
        n   = 4'(i);
        hit = 1'b1;
      end
    end
    return n;
  endfunction

  logic [ROW_W-1:0] store [MEM_DEPTH];
  logic [ROW_W-1:0] rd_data;

  back_state_t      state;
  logic             rd_bank;
  logic [1:0]       step;
  logic [CFG_W-1:0] cur_w;
  logic [ROW_W-1:0] cur_uni;
  logic [CNT_W-1:0] cur_n;
  logic [CFG_W-1:0] left;
  logic [CFG_W-1:0] right;
  logic             found_l;
  logic             found_r;
  logic [4:0]       sh;
  logic             sh_en;
  logic [CFG_W-1:0] real_w;
  logic [CNT_W-1:0] rd_idx;
  logic             inflight;
  logic             inflight_last;
  logic [1:0]       ocnt;
  out_item_t        e0;
  out_item_t        e1;

  logic [ROW_W-1:0] win;
  logic [7:0]       byte_l;
  logic [7:0]       byte_r;
  logic [CFG_W-1:0] left_n;
  logic [CFG_W-1:0] right_n;
  logic             found_l_n;
  logic             found_r_n;
  logic             blank;
  logic [CFG_W-1:0] real_calc;
  logic [2:0]       occ;
  logic             pop_out;
  logic             issue;
  logic             last_issue;
  logic [ROW_W-1:0] cur_mask;
  logic [ROW_W-1:0] row_masked;
  out_item_t        arrive;

  always_ff @(posedge clk) begin
    if (wr.en) store[wr.addr] <= wr.data;
    if (issue) rd_data <= store[{rd_bank, rd_idx[ROW_IDX_W-1:0]}];
  end

  // Measurement: one byte from each end of the cell per cycle.
  always_comb begin
    win       = cur_uni >> (CFG_W'(ROW_W) - cur_w);
    byte_l    = 8'(cur_uni >> (5'd24 - {step, 3'b000}));
    byte_r    = 8'(win >> {step, 3'b000});
    left_n    = left;
    right_n   = right;
    found_l_n = found_l;
    found_r_n = found_r;
    if (!found_l && byte_l != 8'd0) begin
      left_n    = {1'b0, step, 3'b000} + CFG_W'(lzc8(byte_l));
      found_l_n = 1'b1;
    end
    if (!found_r && byte_r != 8'd0) begin
      right_n   = {1'b0, step, 3'b000} + CFG_W'(tzc8(byte_r));
      found_r_n = 1'b1;
    end
    blank = (cur_uni == '0);
    if (blank) real_calc = CFG_W'(({1'b0, cur_w} * 7'd3) >> 3);
    else real_calc = cur_w - left_n - right_n;
  end

  assign pop_out    = out_valid && out_ready;
  assign occ        = {1'b0, ocnt} + {2'b00, inflight};
  assign issue      = (state == ST_EMIT) && ((occ < 3'd2) || pop_out);
  assign last_issue = issue && (rd_idx == cur_n - CNT_W'(1));
  assign q_pop      = last_issue;

  assign cur_mask   = ~({ROW_W{1'b1}} >> cur_w);
  assign row_masked = rd_data & cur_mask;

  always_comb begin
    arrive.row  = sh_en ? (row_masked << sh) : row_masked;
    arrive.rw   = real_w;
    arrive.last = inflight_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      rd_bank       <= 1'b0;
      step          <= 2'd0;
      rd_idx        <= '0;
      inflight      <= 1'b0;
      inflight_last <= 1'b0;
    end else begin
      inflight      <= issue;
      inflight_last <= last_issue;
      case (state)
        ST_IDLE: begin
          if (q_valid) begin
            state <= ST_MEAS;
            step  <= 2'd0;
          end
        end
        ST_MEAS: begin
          step <= step + 2'd1;
          if (step == 2'd3) begin
            state  <= ST_EMIT;
            rd_idx <= '0;
          end
        end
        ST_EMIT: begin
          if (issue) rd_idx <= rd_idx + CNT_W'(1);
          if (last_issue) begin
            state   <= ST_IDLE;
            rd_bank <= !rd_bank;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Glyph parameters, held until the glyph's last row has left the store.
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && q_valid) begin
      cur_w   <= q_desc.width;
      cur_uni <= q_desc.uni;
      cur_n   <= q_desc.rows;
      left    <= '0;
      right   <= '0;
      found_l <= 1'b0;
      found_r <= 1'b0;
    end else if (state == ST_MEAS) begin
      left    <= left_n;
      right   <= right_n;
      found_l <= found_l_n;
      found_r <= found_r_n;
      if (step == 2'd3) begin
        real_w <= real_calc;
        sh     <= left_n[4:0];
        sh_en  <= !blank && (left_n != '0);
      end
    end
  end

  // Two-entry skid buffer on the result side.
  always_ff @(posedge clk) begin
    if (rst) begin
      ocnt <= 2'd0;
    end else begin
      case ({inflight, pop_out})
        2'b10:   ocnt <= ocnt + 2'd1;
        2'b01:   ocnt <= ocnt - 2'd1;
        default: ocnt <= ocnt;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case ({inflight, pop_out})
      2'b10: begin
        if (ocnt == 2'd0) e0 <= arrive;
        else e1 <= arrive;
      end
      2'b01: e0 <= e1;
      2'b11: begin
        if (ocnt == 2'd1) begin
          e0 <= arrive;
        end else begin
          e0 <= e1;
          e1 <= arrive;
        end
      end
      default: ;
    endcase
  end

  assign out_valid   = (ocnt != 2'd0);
  assign trimmed_row = e0.row;
  assign real_width  = e0.rw;
  assign last_row    = e0.last;

endmodule

// ----- hdl/glyph_bitmap_trim.sv -----
// Glyph bitmap trimmer top level: front, descriptor queue and back.
// Depends on gbt_pkg, gbt_front, gbt_queue and gbt_back.
//
// Use: rows of a glyph cell enter on s_axis, one 32-bit row per transaction,
// pixel 0 in bit 31. After glyph_height rows the glyph is complete; its rows
// then leave on m_axis in load order, shifted left past the blank columns,
// each with the glyph's visible width (3/8 of the cell width for a blank glyph); tlast marks the final row.
// Configuration (cfg_index 0 = width, 1 = height) is written with cfg_we
// while no glyph is in progress on the output side.
// The first result of a glyph follows its final row through the queue, the
// measurement at one byte per cycle, the store read and the skid buffer.
// Results then follow one per cycle while m_axis_tready is high.
// Throughput: rows are taken one per cycle while s_axis_tready is high; the
// store holds two glyphs in two banks, so a glyph loads while the previous
// one is emitted. The back measures and emits one glyph at a time;
// s_axis_tready drops while both banks are in use.
// Reset clears all control state; the row store is not cleared. A stall on
// m_axis holds the current result and, once the skid buffer fills, stops
// the store reads; input rows keep loading until both banks are full.
`timescale 1ns / 1ps
module glyph_bitmap_trim import gbt_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_W-1:0]       cfg_wdata,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [ROW_W-1:0]       s_axis_tdata,   // [31:0] row_bits
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [31:0] trimmed_row, [37:32] real_width
  output logic                   m_axis_tlast    // last_row
);

  logic             q_full;
  logic             q_push;
  logic             q_valid;
  logic             q_pop;
  desc_t            push_desc;
  desc_t            head_desc;
  mem_wr_t          wr;
  logic [ROW_W-1:0] trimmed_row;
  logic [CFG_W-1:0] real_width;

  gbt_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .row_valid (s_axis_tvalid),
    .row_ready (s_axis_tready),
    .row_bits  (s_axis_tdata),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_desc    (push_desc),
    .wr        (wr)
  );

  gbt_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_desc (push_desc),
    .full      (q_full),
    .valid     (q_valid),
    .head      (head_desc),
    .pop       (q_pop)
  );

  gbt_back u_back (
    .clk         (clk),
    .rst         (rst),
    .wr          (wr),
    .q_valid     (q_valid),
    .q_desc      (head_desc),
    .q_pop       (q_pop),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .trimmed_row (trimmed_row),
    .real_width  (real_width),
    .last_row    (m_axis_tlast)
  );

  assign m_axis_tdata = {2'b00, real_width, trimmed_row};

endmodule

// ----- hdl/gbt_checker.sv -----
// Port-level checks of the glyph bitmap trimmer, bound to the top level.
// Depends on gbt_pkg and glyph_bitmap_trim.
`timescale 1ns / 1ps
module gbt_checker import gbt_pkg::*; (
  input logic                   clk,
  input logic                   rst,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input logic                   m_axis_tlast
);

  // No result may be pending right after reset.
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("stalled result changed");

  a_width_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[37:32] <= 6'd32) && (m_axis_tdata[39:38] == 2'b00))
    else $error("real width out of range or padding set");

  // Width is one value across all rows of a glyph.
  a_width_const: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
      !m_axis_tvalid || (m_axis_tdata[37:32] == $past(m_axis_tdata[37:32])))
    else $error("real width changed within a glyph");

endmodule

bind glyph_bitmap_trim gbt_checker u_gbt_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

// ----- test/glyph_bitmap_trim_tb.sv -----
// Self-checking testbench for glyph_bitmap_trim: directed table, then random glyphs.
// Rows go in on s_axis, trimmed rows are scored against a built-in trimmer model.
// Depends on gbt_pkg and the glyph_bitmap_trim RTL.
`timescale 1ns / 1ps
module glyph_bitmap_trim_tb;
  import gbt_pkg::*;

  localparam int CLK_PERIOD     = 12;
  localparam int RESET_CYCLES   = 12;
  localparam int MAX_GAP        = 16;
  localparam int SETTLE_CYCLES  = 24;
  localparam int HOLD_CYCLES    = 400;
  localparam int RANDOM_ROWS    = 128;
  localparam int DRAIN_LIMIT    = 20000;
  localparam int TIMEOUT_CYCLES = 300000;

  typedef struct packed {
    logic [ROW_W-1:0] trimmed_row;
    logic [CFG_W-1:0] real_width;
    logic             last_row;
  } trim_row_t;

  typedef enum logic [1:0] {
    STEP_CFG,
    STEP_ROW,
    STEP_ROW_KNOWN
  } step_kind_t;

  typedef struct packed {
    step_kind_t       kind;
    cfg_reg_t         idx;
    logic [CFG_W-1:0] value;
    logic [ROW_W-1:0] bits;
    trim_row_t        want;
  } plan_step_t;

  logic                   clk           = 1'b0;
  logic                   rst           = 1'b1;
  logic                   cfg_we        = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index     = '0;
  logic [CFG_W-1:0]       cfg_wdata     = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [ROW_W-1:0]       s_axis_tdata  = '0;   // [31:0] row_bits
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;         // [31:0] trimmed_row, [37:32] real_width
  logic                   m_axis_tlast;         // last_row

  // Trimmer model state
  logic [ROW_W-1:0] glyph_rows [MAX_HEIGHT];
  logic [ROW_W-1:0] ink_columns = '0;
  int unsigned      rows_held   = 0;
  logic [CFG_W-1:0] width_reg   = WIDTH_RESET;
  logic [CFG_W-1:0] height_reg  = HEIGHT_RESET;
  trim_row_t        trimmed_rows_due [$];

  int err_count = 0;
  bit tx_quiet  = 1'b0;
  bit hold_req  = 1'b0;

  glyph_bitmap_trim dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Zero acts as one, anything above the maximum acts as the maximum.
  function automatic int unsigned clamp_size(input logic [CFG_W-1:0] value,
                                             input int unsigned limit);
    if (value == '0) return 1;
    if (value > limit) return limit;
    return value;
  endfunction

  // Load one row; on the final row of a glyph, queue its trimmed rows.
  // A known row replaces the computed result with the one typed in the table.
  function automatic void load_and_trim(input logic [ROW_W-1:0] bits, input bit known,
                                        input trim_row_t want);
    int unsigned      w, h, lead, trail;
    logic [ROW_W-1:0] mask, ink, r;
    trim_row_t        res;
    w    = clamp_size(width_reg, MAX_WIDTH);
    h    = clamp_size(height_reg, MAX_HEIGHT);
    mask = ~({ROW_W{1'b1}} >> w);
    if (rows_held < MAX_HEIGHT) begin
      glyph_rows[rows_held] = bits & mask;
      rows_held++;
    end
    ink_columns |= bits & mask;
    if (rows_held < h) return;
    ink  = ink_columns & mask;
    lead = 0;
    while (lead < w && !ink[ROW_W-1-lead]) lead++;
    trail = 0;
    while (trail < w && !ink[ROW_W-w+trail]) trail++;
    if (ink == '0) res.real_width = CFG_W'((w * 3) / 8);
    else res.real_width = CFG_W'(w - lead - trail);
    if (known) begin
      trimmed_rows_due.push_back(want);
    end else begin
      for (int k = 0; k < rows_held; k++) begin
        r = glyph_rows[k] & mask;
        // shift only when there is ink and a left margin to drop
        if (lead > 0 && lead < w) r = r << lead;
        res.trimmed_row = r;
        res.last_row    = (k + 1 == rows_held);
        trimmed_rows_due.push_back(res);
      end
    end
    ink_columns = '0;
    rows_held   = 0;
  endfunction

  function automatic void take_trimmed_row();
    trim_row_t want;
    if (trimmed_rows_due.size() == 0) begin
      $error("unexpected result: trimmed_row %h real_width %0d last_row %b",
             m_axis_tdata[ROW_W-1:0], m_axis_tdata[ROW_W +: CFG_W], m_axis_tlast);
      err_count++;
      return;
    end
    want = trimmed_rows_due.pop_front();
    if (m_axis_tdata[ROW_W-1:0] !== want.trimmed_row) begin
      $error("trimmed_row: expected %h, got %h", want.trimmed_row, m_axis_tdata[ROW_W-1:0]);
      err_count++;
    end
    if (m_axis_tdata[ROW_W +: CFG_W] !== want.real_width) begin
      $error("real_width: expected %0d, got %0d", want.real_width,
             m_axis_tdata[ROW_W +: CFG_W]);
      err_count++;
    end
    if (m_axis_tlast !== want.last_row) begin
      $error("last_row: expected %b, got %b", want.last_row, m_axis_tlast);
      err_count++;
    end
  endfunction

  function automatic logic [ROW_W-1:0] random_glyph_row();
    int unsigned lo, hi;
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return 32'h1 << $urandom_range(0, 31);
      3, 4: begin
        // ink confined to a band of columns
        lo = $urandom_range(0, 31);
        hi = $urandom_range(lo + 1, 32);
        return $urandom() & (32'hFFFF_FFFF >> lo) & ~(32'hFFFF_FFFF >> hi);
      end
      default: return $urandom();
    endcase
  endfunction

  function automatic plan_step_t cfg_step(input cfg_reg_t idx, input logic [CFG_W-1:0] value);
    plan_step_t s;
    s       = '0;
    s.kind  = STEP_CFG;
    s.idx   = idx;
    s.value = value;
    return s;
  endfunction

  function automatic plan_step_t row_step(input logic [ROW_W-1:0] bits);
    plan_step_t s;
    s      = '0;
    s.kind = STEP_ROW;
    s.bits = bits;
    return s;
  endfunction

  // Single-row glyph whose result is read off by hand.
  function automatic plan_step_t known_step(input logic [ROW_W-1:0] bits,
                                            input logic [ROW_W-1:0] trimmed,
                                            input logic [CFG_W-1:0] vis_width);
    plan_step_t s;
    s                  = '0;
    s.kind             = STEP_ROW_KNOWN;
    s.bits             = bits;
    s.want.trimmed_row = trimmed;
    s.want.real_width  = vis_width;
    s.want.last_row    = 1'b1;
    return s;
  endfunction

  // Write a register once the output side has drained and the back has settled.
  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] value);
    s_axis_tvalid <= 1'b0;
    while (trimmed_rows_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_WIDTH) width_reg = value;
    else height_reg = value;
  endtask

  // Offer one row; valid stays high into the next row when no gap is drawn.
  task automatic send_row(input logic [ROW_W-1:0] bits, input bit known,
                          input trim_row_t want);
    int gap;
    gap = tx_quiet ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= bits;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    load_and_trim(bits, known, want);
  endtask

  initial begin : result_sink
    int gap;
    int fast_left;
    bit held;
    fast_left = 0;
    held      = 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req && !held) begin
        // hold off long enough for both banks to fill
        held = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        gap = 0;
      end else if (fast_left > 0) begin
        fast_left--;
        gap = 0;
      end else begin
        gap = $urandom_range(0, MAX_GAP);
        if ($urandom_range(0, 24) == 0) fast_left = 40;
      end
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk);
      while (!m_axis_tvalid) @(posedge clk);
      take_trimmed_row();
    end
  end

  initial begin : stimulus
    plan_step_t       plan [$];
    int               phase, glyphs, partial, sent;
    int unsigned      h_eff;
    logic [CFG_W-1:0] w_set, h_set;

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    plan.push_back(cfg_step(REG_HEIGHT, 6'd1));
    plan.push_back(cfg_step(REG_WIDTH, 6'd32));
    plan.push_back(known_step(32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd32));
    plan.push_back(known_step(32'h0000_0000, 32'h0000_0000, 6'd12));   // blank glyph
    plan.push_back(known_step(32'h0000_0001, 32'h8000_0000, 6'd1));
    plan.push_back(known_step(32'h8000_0000, 32'h8000_0000, 6'd1));
    plan.push_back(cfg_step(REG_WIDTH, 6'd8));
    plan.push_back(known_step(32'h1800_0000, 32'hC000_0000, 6'd2));
    plan.push_back(known_step(32'h00FF_FFFF, 32'h0000_0000, 6'd3));    // ink only in padding
    plan.push_back(known_step(32'h01FF_FFFF, 32'h8000_0000, 6'd1));
    plan.push_back(cfg_step(REG_WIDTH, 6'd0));                         // acts as one
    plan.push_back(known_step(32'h7FFF_FFFF, 32'h0000_0000, 6'd0));
    plan.push_back(known_step(32'hFFFF_FFFF, 32'h8000_0000, 6'd1));
    plan.push_back(cfg_step(REG_WIDTH, 6'd63));                        // acts as 32
    plan.push_back(known_step(32'h0000_FFFF, 32'hFFFF_0000, 6'd16));
    plan.push_back(cfg_step(REG_HEIGHT, 6'd0));                        // acts as one
    plan.push_back(known_step(32'h00F0_0F00, 32'hF00F_0000, 6'd16));
    plan.push_back(cfg_step(REG_HEIGHT, 6'd3));
    plan.push_back(cfg_step(REG_WIDTH, 6'd16));
    plan.push_back(row_step(32'h1234_5678));
    plan.push_back(row_step(32'h00FF_0000));
    plan.push_back(row_step(32'h0000_FFFF));
    // height changed between glyphs, then width changed with half a glyph loaded
    plan.push_back(cfg_step(REG_HEIGHT, 6'd4));
    plan.push_back(row_step(32'h0F0F_0000));
    plan.push_back(row_step(32'h0030_0000));
    plan.push_back(cfg_step(REG_WIDTH, 6'd12));
    plan.push_back(row_step(32'h3FF0_FFFF));
    plan.push_back(row_step(32'h0010_0000));
    // height raised to 32, then dropped to 2 below the rows already loaded
    plan.push_back(cfg_step(REG_HEIGHT, 6'd32));
    plan.push_back(cfg_step(REG_WIDTH, 6'd32));
    plan.push_back(row_step(32'h0001_8000));
    plan.push_back(row_step(32'h0003_C000));
    plan.push_back(row_step(32'h0007_E000));
    plan.push_back(row_step(32'h0000_0000));
    plan.push_back(cfg_step(REG_HEIGHT, 6'd2));
    plan.push_back(row_step(32'h0000_0100));

    foreach (plan[i]) begin
      case (plan[i].kind)
        STEP_CFG:       write_reg(plan[i].idx, plan[i].value);
        STEP_ROW:       send_row(plan[i].bits, 1'b0, '0);
        STEP_ROW_KNOWN: send_row(plan[i].bits, 1'b1, plan[i].want);
        default:        ;
      endcase
    end

    phase = 0;
    sent  = 0;
    while (sent < RANDOM_ROWS) begin
      case (phase)
        0: begin w_set = WIDTH_RESET; h_set = HEIGHT_RESET; glyphs = 1; end
        1: begin w_set = 6'd32; h_set = 6'd32; glyphs = 1; end
        2: begin w_set = 6'd63; h_set = 6'd3;  glyphs = 8; end
        3: begin w_set = 6'd1;  h_set = 6'd1;  glyphs = 4; end
        4: begin w_set = 6'd0;  h_set = 6'd0;  glyphs = 3; end
        5: begin w_set = 6'd32; h_set = 6'd63; glyphs = 1; end
        default: begin
          w_set  = ($urandom_range(0, 7) == 0) ? CFG_W'($urandom_range(0, 63))
                                               : CFG_W'($urandom_range(1, 32));
          h_set  = ($urandom_range(0, 9) == 0) ? CFG_W'($urandom_range(0, 63))
                                               : CFG_W'($urandom_range(1, 6));
          glyphs = $urandom_range(1, 3);
        end
      endcase
      write_reg(REG_WIDTH, w_set);
      write_reg(REG_HEIGHT, h_set);
      if (phase == 2) hold_req = 1'b1;
      tx_quiet = (phase == 2) || ($urandom_range(0, 3) == 0);
      h_eff    = clamp_size(h_set, MAX_HEIGHT);
      // leave a glyph partly loaded so the next register write lands mid-glyph
      partial  = 0;
      if (phase > 5 && h_eff > 1 && $urandom_range(0, 3) == 0)
        partial = $urandom_range(1, h_eff - 1);
      repeat (glyphs * h_eff + partial) begin
        send_row(random_glyph_row(), 1'b0, '0);
        sent++;
      end
      phase++;
    end

    s_axis_tvalid <= 1'b0;
    for (int i = 0; i < DRAIN_LIMIT && trimmed_rows_due.size() != 0; i++) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (trimmed_rows_due.size() != 0) begin
      $error("%0d trimmed rows never arrived", trimmed_rows_due.size());
      err_count++;
    end
    if (err_count == 0) begin
      $display("glyph_bitmap_trim_tb: PASS");
    end else begin
      $display("glyph_bitmap_trim_tb: FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("glyph_bitmap_trim_tb: FAIL");
    $finish;
  end

endmodule
